// ----- design/odd_poly_sign_approx_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the odd sign-approximation polynomial block
// Shared wrappers that keep the concurrent checks in the top level short.
// ----------------------------------------------------------------------------
`ifndef ODD_POLY_SIGN_APPROX_MACROS_SVH
`define ODD_POLY_SIGN_APPROX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OPS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ops_pkg.sv -----
// ----------------------------------------------------------------------------
// Odd sign-approximation polynomial package
// Shared widths, command codes and the coefficient table.
// ----------------------------------------------------------------------------
package ops_pkg;

	localparam int DATA_W        = 32;
	localparam int CMD_W         = 4;
	localparam int FRAC_BITS_DEF = 30;
	localparam int ACC_INT_W     = 18;   // integer bits of the Horner accumulator
	localparam int T_INT_W       = 4;    // integer bits of x squared
	localparam int COEF_W        = 18;
	localparam int COEF_FRAC     = 10;
	localparam int NUM_TERMS     = 5;
	localparam int NUM_POLYS     = 8;
	localparam int POLY_SEL_W    = $clog2(NUM_POLYS);
	localparam int TERM_IDX_W    = $clog2(NUM_TERMS);

	typedef logic [CMD_W-1:0]             cmd_t;
	typedef logic [TERM_IDX_W-1:0]        term_idx_t;
	typedef logic signed [COEF_W-1:0]     coef_t;

	localparam cmd_t CMD_POLY_FIRST = 4'd0;
	localparam cmd_t CMD_POLY_LAST  = 4'd7;
	localparam cmd_t CMD_HALF       = 4'd8;

	localparam logic signed [DATA_W-1:0] Y_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] Y_MIN = 32'sh8000_0000;

	// Odd coefficients c9, c7, c5, c3, c1, each an integer over 2^10.
	localparam coef_t COEF_TAB [NUM_POLYS][NUM_TERMS] = '{
		'{     18'sd0,       18'sd0,      18'sd0,   -18'sd512,  18'sd1536 },
		'{     18'sd0,       18'sd0,    18'sd384,  -18'sd1280,  18'sd1920 },
		'{     18'sd0,    -18'sd320,   18'sd1344,  -18'sd2240,  18'sd2240 },
		'{   18'sd280,   -18'sd1440,   18'sd3024,  -18'sd3360,  18'sd2520 },
		'{     18'sd0,       18'sd0,      18'sd0,  -18'sd1359,  18'sd2126 },
		'{     18'sd0,       18'sd0,   18'sd3796,  -18'sd6108,  18'sd3334 },
		'{     18'sd0,  -18'sd12860,  18'sd25614, -18'sd16577,  18'sd4589 },
		'{ 18'sd46623, -18'sd113492,  18'sd97015, -18'sd34974,  18'sd5850 }
	};

	// Coefficient of term k for a command; commands outside the polynomial
	// set read as zero.
	function automatic coef_t coef_lookup(cmd_t cmd, term_idx_t k);
		coef_t c;
		c = '0;
		if (cmd <= CMD_POLY_LAST && k < TERM_IDX_W'(NUM_TERMS)) begin
			c = COEF_TAB[cmd[POLY_SEL_W-1:0]][k];
		end
		return c;
	endfunction

endpackage

// ----- design/ops_mul_cell.sv -----
// ----------------------------------------------------------------------------
// Multiply-accumulate cell
// Computes floor(a * b / 2^FRAC_BITS) + c over two registered stages and
// carries a sideband word along with the transaction.
// ----------------------------------------------------------------------------
module ops_mul_cell #(
	parameter int FRAC_BITS = ops_pkg::FRAC_BITS_DEF,
	parameter int A_W       = FRAC_BITS + ops_pkg::ACC_INT_W,
	parameter int B_W       = FRAC_BITS + ops_pkg::T_INT_W,
	parameter int SIDE_W    = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	input  logic signed [A_W-1:0]    c,
	input  logic [SIDE_W-1:0]        side_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [A_W-1:0]    r,
	output logic [SIDE_W-1:0]        side_out
);

	localparam int AH_W  = A_W - FRAC_BITS;
	localparam int HI_W  = AH_W + B_W;
	localparam int LOF_W = FRAC_BITS + 1 + B_W;
	localparam int LO_W  = LOF_W - FRAC_BITS;
	localparam int SUM_W = ((HI_W > A_W) ? HI_W : A_W) + 1;

	logic signed [AH_W-1:0]  ah;
	logic [FRAC_BITS-1:0]    al;
	logic signed [HI_W-1:0]  hi;
	logic signed [LOF_W-1:0] lo_full;
	logic signed [LO_W-1:0]  lo;

	logic                    v_s1, v_s2;
	logic                    rdy_s1, rdy_s2;
	logic signed [HI_W-1:0]  hi_s1;
	logic signed [LO_W-1:0]  lo_s1;
	logic signed [A_W-1:0]   c_s1;
	logic [SIDE_W-1:0]       side_s1;
	logic signed [SUM_W-1:0] sum;
	logic signed [A_W-1:0]   r_s2;
	logic [SIDE_W-1:0]       side_s2;

	// Split a into a signed high part and an unsigned low part so that each
	// partial product stays near 32 by 32 bits.
	always_comb begin
		ah      = a[A_W-1:FRAC_BITS];
		al      = a[FRAC_BITS-1:0];
		hi      = ah * b;
		lo_full = $signed({1'b0, al}) * b;
		lo      = lo_full[LOF_W-1:FRAC_BITS];
	end

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			hi_s1   <= hi;
			lo_s1   <= lo;
			c_s1    <= c;
			side_s1 <= side_in;
		end
	end

	assign sum = {{(SUM_W-HI_W){hi_s1[HI_W-1]}}, hi_s1}
		+ {{(SUM_W-LO_W){lo_s1[LO_W-1]}}, lo_s1}
		+ {{(SUM_W-A_W){c_s1[A_W-1]}}, c_s1};

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			r_s2    <= sum[A_W-1:0];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign r         = r_s2;
	assign side_out  = side_s2;

endmodule

// ----- design/ops_out.sv -----
// ----------------------------------------------------------------------------
// Result stage
// Selects the result by command, saturates it to 32 bits and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module ops_out #(
	parameter int FRAC_BITS = ops_pkg::FRAC_BITS_DEF,
	parameter int A_W       = FRAC_BITS + ops_pkg::ACC_INT_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ops_pkg::cmd_t                     cmd,
	input  logic signed [ops_pkg::DATA_W-1:0] x,
	input  logic signed [A_W-1:0]             r,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ops_pkg::DATA_W-1:0] y,
	output logic                              saturated
);

	localparam int DW = ops_pkg::DATA_W;
	localparam logic signed [DW:0] ONE = {{DW{1'b0}}, 1'b1} << FRAC_BITS;

	logic signed [DW:0]   x_plus_one;
	logic                 fits;
	logic signed [DW-1:0] y_d;
	logic                 sat_d;
	logic                 valid_q;
	logic signed [DW-1:0] y_q;
	logic                 sat_q;

	always_comb begin
		x_plus_one = {x[DW-1], x} + ONE;
		fits       = (&r[A_W-1:DW-1]) || !(|r[A_W-1:DW-1]);
		y_d        = '0;
		sat_d      = 1'b0;
		if (cmd == ops_pkg::CMD_HALF) begin
			y_d = x_plus_one[DW:1];
		end else if (cmd inside {[ops_pkg::CMD_POLY_FIRST:ops_pkg::CMD_POLY_LAST]}) begin
			if (fits) begin
				y_d = r[DW-1:0];
			end else begin
				sat_d = 1'b1;
				y_d   = r[A_W-1] ? ops_pkg::Y_MIN : ops_pkg::Y_MAX;
			end
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			y_q   <= y_d;
			sat_q <= sat_d;
		end
	end

	assign out_valid = valid_q;
	assign y         = y_q;
	assign saturated = sat_q;

endmodule

// ----- design/odd_poly_sign_approx.sv -----
// ----------------------------------------------------------------------------
// Odd sign-approximation polynomial evaluator
// Evaluates the f1..f4 and g1..g4 polynomials, or (x+1)/2, on a Q2.30 value.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction carries a command and a signed fixed-point x; it is
// taken on a rising edge where item_valid and item_ready are both high.
// Commands 0 to 3 select f1..f4, 4 to 7 select g1..g4, 8 gives (x+1)/2 and
// any other command gives zero. Each input transaction yields exactly one
// result transaction (y and saturated) on the result channel, in order.
// The datapath is a row of six identical multiply cells: one forms x squared,
// four run the Horner steps in x squared, and one multiplies by x. Each cell
// has two register stages and the result stage adds one more, so a result is
// presented from the output register after passing through all six cells.
// Throughput is one transaction per cycle while result_ready is high, set by the
// two-stage cell; each cell stage advances on its own, so bubbles are filled while stalled.
// When the receiver holds result_ready low the finished result waits in the
// output register and stages behind it fill up; item_ready drops only once
// every stage holds a transaction.
// Reset clears all valid bits at once; no result is presented after reset
// until a new input transaction has gone through.
// ----------------------------------------------------------------------------
`include "odd_poly_sign_approx_macros.svh"

module odd_poly_sign_approx #(
	parameter int FRAC_BITS = ops_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  ops_pkg::cmd_t                     command,
	input  logic signed [ops_pkg::DATA_W-1:0] x,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic signed [ops_pkg::DATA_W-1:0] y,
	output logic                              saturated
);

	localparam int DW        = ops_pkg::DATA_W;
	localparam int A_W       = FRAC_BITS + ops_pkg::ACC_INT_W;
	localparam int B_W       = FRAC_BITS + ops_pkg::T_INT_W;
	localparam int XC_W      = FRAC_BITS + 2;
	localparam int T_W       = B_W;
	localparam int NUM_CELLS = ops_pkg::NUM_TERMS + 1;
	localparam int LAST      = NUM_CELLS - 1;

	// Sideband word that rides along the cell row: {command, x, xc, t}.
	localparam int T_LSB   = 0;
	localparam int XC_LSB  = T_LSB + T_W;
	localparam int X_LSB   = XC_LSB + XC_W;
	localparam int CMD_LSB = X_LSB + DW;
	localparam int SIDE_W  = CMD_LSB + ops_pkg::CMD_W;

	// Clip range for the polynomial input: [-2.0, 2.0 - 2^-FRAC_BITS].
	localparam logic signed [DW:0] X_LO = -({{DW{1'b0}}, 1'b1} << (FRAC_BITS + 1));
	localparam logic signed [DW:0] X_HI = ({{DW{1'b0}}, 1'b1} << (FRAC_BITS + 1)) - 1;

	// A coefficient c/1024 held exactly with FRAC_BITS fraction bits.
	function automatic logic signed [A_W-1:0] scale_coef(ops_pkg::coef_t c);
		logic [A_W-1:0] ext;
		ext = {{(A_W-ops_pkg::COEF_W){c[ops_pkg::COEF_W-1]}}, c};
		return ext << (FRAC_BITS - ops_pkg::COEF_FRAC);
	endfunction

	logic signed [DW:0]     x_ext;
	logic signed [DW:0]     x_clip;
	logic signed [XC_W-1:0] xc;

	logic                   v_i    [NUM_CELLS];
	logic                   rdy_o  [NUM_CELLS];
	logic                   v_o    [NUM_CELLS];
	logic                   rdy_dn [NUM_CELLS];
	logic signed [A_W-1:0]  a_i    [NUM_CELLS];
	logic signed [B_W-1:0]  b_i    [NUM_CELLS];
	logic signed [A_W-1:0]  c_i    [NUM_CELLS];
	logic signed [A_W-1:0]  r_o    [NUM_CELLS];
	logic [SIDE_W-1:0]      side_i [NUM_CELLS];
	logic [SIDE_W-1:0]      side_o [NUM_CELLS];

	logic                   res_rdy;

	// Only the polynomial commands use the clipped value; command 8 takes x
	// as it is from the sideband.
	always_comb begin
		x_ext  = {x[DW-1], x};
		x_clip = x_ext;
		if (x_ext < X_LO) begin
			x_clip = X_LO;
		end else if (x_ext > X_HI) begin
			x_clip = X_HI;
		end
		xc = x_clip[XC_W-1:0];
	end

	assign item_ready = rdy_o[0];

	for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
		ops_pkg::cmd_t        cmd_j;
		logic [T_W-1:0]       t_j;
		logic signed [XC_W-1:0] xc_j;

		if (j == 0) begin : g_square
			// First cell forms t = floor(xc * xc / 2^FRAC_BITS).
			assign cmd_j     = command;
			assign t_j       = '0;
			assign xc_j      = xc;
			assign v_i[j]    = item_valid;
			assign a_i[j]    = {{(A_W-XC_W){xc[XC_W-1]}}, xc};
			assign b_i[j]    = {{(B_W-XC_W){xc[XC_W-1]}}, xc};
			assign c_i[j]    = '0;
			assign side_i[j] = {cmd_j, x, xc_j, t_j};
		end else if (j == 1) begin : g_first_step
			// The accumulator starts at the top coefficient, so the first Horner
			// step multiplies that constant by t and adds the next coefficient.
			assign cmd_j     = side_o[j-1][CMD_LSB +: ops_pkg::CMD_W];
			assign t_j       = r_o[j-1][T_W-1:0];
			assign xc_j      = side_o[j-1][XC_LSB +: XC_W];
			assign v_i[j]    = v_o[j-1];
			assign a_i[j]    = scale_coef(ops_pkg::coef_lookup(cmd_j, '0));
			assign b_i[j]    = t_j;
			assign c_i[j]    = scale_coef(ops_pkg::coef_lookup(cmd_j,
				ops_pkg::term_idx_t'(j)));
			assign side_i[j] = {cmd_j, side_o[j-1][X_LSB +: DW], xc_j, t_j};
		end else if (j < LAST) begin : g_step
			assign cmd_j     = side_o[j-1][CMD_LSB +: ops_pkg::CMD_W];
			assign t_j       = side_o[j-1][T_LSB +: T_W];
			assign xc_j      = side_o[j-1][XC_LSB +: XC_W];
			assign v_i[j]    = v_o[j-1];
			assign a_i[j]    = r_o[j-1];
			assign b_i[j]    = t_j;
			assign c_i[j]    = scale_coef(ops_pkg::coef_lookup(cmd_j,
				ops_pkg::term_idx_t'(j)));
			assign side_i[j] = {cmd_j, side_o[j-1][X_LSB +: DW], xc_j, t_j};
		end else begin : g_final
			// Last cell multiplies the odd part by the clipped x.
			assign cmd_j     = side_o[j-1][CMD_LSB +: ops_pkg::CMD_W];
			assign t_j       = side_o[j-1][T_LSB +: T_W];
			assign xc_j      = side_o[j-1][XC_LSB +: XC_W];
			assign v_i[j]    = v_o[j-1];
			assign a_i[j]    = r_o[j-1];
			assign b_i[j]    = {{(B_W-XC_W){xc_j[XC_W-1]}}, xc_j};
			assign c_i[j]    = '0;
			assign side_i[j] = {cmd_j, side_o[j-1][X_LSB +: DW], xc_j, t_j};
		end

		if (j < LAST) begin : g_dn_cell
			assign rdy_dn[j] = rdy_o[j+1];
		end else begin : g_dn_out
			assign rdy_dn[j] = res_rdy;
		end

		ops_mul_cell #(
			.FRAC_BITS (FRAC_BITS),
			.A_W       (A_W),
			.B_W       (B_W),
			.SIDE_W    (SIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_i[j]),
			.in_ready  (rdy_o[j]),
			.a         (a_i[j]),
			.b         (b_i[j]),
			.c         (c_i[j]),
			.side_in   (side_i[j]),
			.out_valid (v_o[j]),
			.out_ready (rdy_dn[j]),
			.r         (r_o[j]),
			.side_out  (side_o[j])
		);
	end

	ops_out #(
		.FRAC_BITS (FRAC_BITS),
		.A_W       (A_W)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_o[LAST]),
		.in_ready  (res_rdy),
		.cmd       (side_o[LAST][CMD_LSB +: ops_pkg::CMD_W]),
		.x         (side_o[LAST][X_LSB +: DW]),
		.r         (r_o[LAST]),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.y         (y),
		.saturated (saturated)
	);

	// A clipped result is always one of the two range limits.
	`OPS_ASSERT_SAME(a_sat_limit, clk, arst_n, result_valid && saturated, (y == ops_pkg::Y_MAX || y == ops_pkg::Y_MIN), "saturated result is not a range limit")

	// While a result waits, the last cell must not hand over another one.
	`OPS_ASSERT_SAME(a_hold_last, clk, arst_n, result_valid && !result_ready, !res_rdy, "result stage took a transaction while full")

	// A transaction handed from the last cell shows up on the result channel.
	`OPS_ASSERT_NEXT(a_last_to_out, clk, arst_n, v_o[LAST] && res_rdy, result_valid, "handed-over transaction did not reach the output")

endmodule
